// ===== rtl/dilated_time_clock_assert.svh =====
// assertion helpers for the dilated time clock checker
// both expect clk and rst_n in scope
`ifndef DILATED_TIME_CLOCK_ASSERT_SVH
`define DILATED_TIME_CLOCK_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DTC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dilated_time_clock: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define DTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dilated_time_clock: next-cycle check failed");

`endif

// ===== rtl/dtc_pkg.sv =====
package dtc_pkg;

    localparam int SEC_W    = 32;
    localparam int USEC_W   = 20;
    localparam int FACTOR_W = 16;
    // microsecond counts up to about 2^53 (base plus elapsed)
    localparam int MICROS_W = 53;
    localparam int DATA_W   = 72;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [USEC_W-1:0] USEC_MAX     = USEC_W'(999999);

    localparam logic REQ_READ       = 1'b0;
    localparam logic REQ_SET_FACTOR = 1'b1;

endpackage

// ===== rtl/dtc_micros.sv =====
module dtc_micros
    import dtc_pkg::*;
(
    input  logic                clk,
    input  logic [SEC_W-1:0]    sec,
    input  logic [USEC_W-1:0]   usec,
    output logic [MICROS_W-1:0] micros
);

    logic [MICROS_W-1:0] micros_reg;
    logic [MICROS_W-1:0] micros_next;

    // seconds times one million plus microseconds, registered
    always_comb
    begin
        micros_next = MICROS_W'(sec) * MICROS_W'(USEC_PER_SEC) + MICROS_W'(usec);
    end

    always_ff @(posedge clk)
    begin
        micros_reg <= micros_next;
    end

    assign micros = micros_reg;

endmodule

// ===== rtl/dtc_div.sv =====
module dtc_div
    import dtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MICROS_W-1:0] dividend,
    input  logic [USEC_W-1:0]   divisor,
    output logic [MICROS_W-1:0] quotient,
    output logic [USEC_W-1:0]   remainder,
    output logic                done
);

    localparam int CNT_W = $clog2(MICROS_W);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [MICROS_W-1:0] dvd_reg,   dvd_next;
    logic [USEC_W-1:0]   rem_reg,   rem_next;
    logic [USEC_W-1:0]   dsr_reg,   dsr_next;

    logic [USEC_W:0]     shifted;
    logic [USEC_W:0]     diff;
    logic                ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[MICROS_W-1]};
        ge      = (shifted >= {1'b0, dsr_reg});
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[MICROS_W-2:0], ge};
            rem_next = ge ? diff[USEC_W-1:0] : shifted[USEC_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MICROS_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== rtl/dilated_time_clock.sv =====
// Dilated time clock: every transaction on the slave side carries a real-time
// sample and returns base + (real - reference) / factor as seconds and
// microseconds, plus the factor in force afterwards. The first transaction
// after reset captures its sample as base and reference; a set-factor request
// with a new nonzero factor rebases the clock on the dilated time it returns.
// A request passes ST_MUL_NOW, ST_SPAN, ST_DIV_SPAN, ST_DIV_NORM, ST_OUT, with
// ST_MUL_BASE and ST_REBASE before ST_OUT when it rebases: one radix-2 divider,
// one quotient bit per cycle over 53 bits then a done strobe, runs twice (the
// elapsed microseconds by the factor, then the dilated total by one million),
// after the registered seconds-to-microseconds multiply, which a rebase runs
// again on the dilated time. s_tready is high only while no request is in work,
// so the next request can be accepted in the same cycle as the result is
// presented; a finished result waits in the output register without blocking
// the next request, which then holds in ST_OUT until that register is free.
module dilated_time_clock
    import dtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // real_sec [31:0], real_usec [51:32], new_factor [67:52], zero [71:68]
    input  logic [DATA_W-1:0] s_tdata,
    // req_type [0]
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // dilated_sec [31:0], dilated_usec [51:32], factor_now [67:52], zero [71:68]
    output logic [DATA_W-1:0] m_tdata
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL_NOW  = 8'b0000_0010,
        ST_SPAN     = 8'b0000_0100,
        ST_DIV_SPAN = 8'b0000_1000,
        ST_DIV_NORM = 8'b0001_0000,
        ST_MUL_BASE = 8'b0010_0000,
        ST_REBASE   = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t              state_reg,   state_next;
    logic                kind_reg,    kind_next;
    logic [SEC_W-1:0]    rsec_reg,    rsec_next;
    logic [USEC_W-1:0]   rusec_reg,   rusec_next;
    logic [FACTOR_W-1:0] nf_reg,      nf_next;
    logic                started_reg, started_next;
    logic [MICROS_W-1:0] base_reg,    base_next;
    logic [MICROS_W-1:0] ref_reg,     ref_next;
    logic [FACTOR_W-1:0] dil_reg,     dil_next;
    logic [SEC_W-1:0]    res_sec_reg, res_sec_next;
    logic [USEC_W-1:0]   res_usec_reg, res_usec_next;
    logic                m_valid_reg, m_valid_next;
    logic [SEC_W-1:0]    out_sec_reg, out_sec_next;
    logic [USEC_W-1:0]   out_usec_reg, out_usec_next;
    logic [FACTOR_W-1:0] out_fac_reg, out_fac_next;

    logic [USEC_W-1:0]   in_usec;
    logic [SEC_W-1:0]    mul_sec;
    logic [USEC_W-1:0]   mul_usec;
    logic [MICROS_W-1:0] mul_q;
    logic [MICROS_W-1:0] ref_eff;
    logic                div_start;
    logic [MICROS_W-1:0] div_dividend;
    logic [USEC_W-1:0]   div_divisor;
    logic [MICROS_W-1:0] div_quot;
    logic [USEC_W-1:0]   div_rem;
    logic                div_done;
    logic                rebase;

    assign in_usec = (s_tdata[51:32] >= USEC_PER_SEC) ? USEC_MAX : s_tdata[51:32];

    // the multiplier serves the sample first, then the rebased dilated time
    assign mul_sec  = (state_reg == ST_MUL_BASE) ? res_sec_reg  : rsec_reg;
    assign mul_usec = (state_reg == ST_MUL_BASE) ? res_usec_reg : rusec_reg;

    dtc_micros u_micros (
        .clk    (clk),
        .sec    (mul_sec),
        .usec   (mul_usec),
        .micros (mul_q)
    );

    dtc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    // before the first sample the reference is the sample itself
    assign ref_eff = started_reg ? ref_reg : mul_q;
    assign rebase  = (kind_reg == REQ_SET_FACTOR) && (nf_reg != '0) && (nf_reg != dil_reg);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = (mul_q > ref_eff) ? (mul_q - ref_eff) : '0;
        div_divisor  = USEC_W'(dil_reg);
        if (state_reg == ST_SPAN)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == ST_DIV_SPAN)
        begin
            div_start    = div_done;
            div_dividend = base_reg + div_quot;
            div_divisor  = USEC_PER_SEC;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        rsec_next     = rsec_reg;
        rusec_next    = rusec_reg;
        nf_next       = nf_reg;
        started_next  = started_reg;
        base_next     = base_reg;
        ref_next      = ref_reg;
        dil_next      = dil_reg;
        res_sec_next  = res_sec_reg;
        res_usec_next = res_usec_reg;
        m_valid_next  = m_valid_reg;
        out_sec_next  = out_sec_reg;
        out_usec_next = out_usec_reg;
        out_fac_next  = out_fac_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    rsec_next  = s_tdata[31:0];
                    rusec_next = in_usec;
                    nf_next    = s_tdata[67:52];
                    state_next = ST_MUL_NOW;
                end
            end
            ST_MUL_NOW:
            begin
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    base_next    = mul_q;
                    ref_next     = mul_q;
                end
                state_next = ST_DIV_SPAN;
            end
            ST_DIV_SPAN:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_NORM;
                end
            end
            ST_DIV_NORM:
            begin
                if (div_done)
                begin
                    res_sec_next  = div_quot[SEC_W-1:0];
                    res_usec_next = div_rem;
                    if (rebase)
                    begin
                        dil_next   = nf_reg;
                        ref_next   = mul_q;
                        state_next = ST_MUL_BASE;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MUL_BASE:
            begin
                state_next = ST_REBASE;
            end
            ST_REBASE:
            begin
                base_next  = mul_q;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_sec_next  = res_sec_reg;
                    out_usec_next = res_usec_reg;
                    out_fac_next  = dil_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            base_reg    <= '0;
            ref_reg     <= '0;
            dil_reg     <= FACTOR_W'(1);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            base_reg    <= base_next;
            ref_reg     <= ref_next;
            dil_reg     <= dil_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        rsec_reg     <= rsec_next;
        rusec_reg    <= rusec_next;
        nf_reg       <= nf_next;
        res_sec_reg  <= res_sec_next;
        res_usec_reg <= res_usec_next;
        out_sec_reg  <= out_sec_next;
        out_usec_reg <= out_usec_next;
        out_fac_reg  <= out_fac_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, out_fac_reg, out_usec_reg, out_sec_reg};

endmodule

// ===== rtl/dtc_checker.sv =====
`include "dilated_time_clock_assert.svh"

module dtc_checker
    import dtc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [DATA_W-1:0] s_tdata,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // a stalled result holds
    `DTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one request in work at a time
    `DTC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // microseconds are normalized
    `DTC_ASSERT_SAME(a_usec_range, m_tvalid, m_tdata[51:32] < USEC_PER_SEC)
    // the factor in force is never zero
    `DTC_ASSERT_SAME(a_factor_nonzero, m_tvalid, m_tdata[67:52] != '0)

endmodule

bind dilated_time_clock dtc_checker u_dtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
